### sv/lecp_pkg.sv
`default_nettype none
package lecp_pkg;

	// Default line capacity. The line holds at most one character fewer.
	localparam int LINE_CAPACITY_DEF = 64;
	// Default depth of the job queue between the front and back parts.
	localparam int QUEUE_DEPTH_DEF   = 2;
	// Only the first characters of the line are ever matched ("OFF" is the longest).
	localparam int HEAD_N            = 3;

	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TIL = 8'h7E;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_GT  = 8'h3E;

	localparam logic [6:0] CH_UO = 7'h4F; // 'O'
	localparam logic [6:0] CH_LO = 7'h6F; // 'o'
	localparam logic [6:0] CH_UN = 7'h4E; // 'N'
	localparam logic [6:0] CH_LN = 7'h6E; // 'n'
	localparam logic [6:0] CH_UF = 7'h46; // 'F'
	localparam logic [6:0] CH_LF7 = 7'h66; // 'f'

	typedef enum logic [2:0] {
		EV_NONE        = 3'd0,
		EV_ON          = 3'd1,
		EV_ALREADY_ON  = 3'd2,
		EV_OFF         = 3'd3,
		EV_ALREADY_OFF = 3'd4,
		EV_UNKNOWN     = 3'd5
	} event_t;

	// Kind of reply run the back part plays out.
	typedef enum logic [1:0] {
		K_ECHO  = 2'd0, // the character itself
		K_ERASE = 2'd1, // BS SP BS
		K_CMD   = 2'd2, // CR LF > SP BS BS SP BS > SP
		K_UNK   = 2'd3  // CR LF > SP > SP
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		event_t     ev;
		logic       on;
	} job_t;

	function automatic logic [3:0] run_len(kind_t k);
		logic [3:0] n;
		case (k)
			K_ECHO:  n = 4'd1;
			K_ERASE: n = 4'd3;
			K_CMD:   n = 4'd10;
			K_UNK:   n = 4'd6;
			default: n = 4'd1;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] run_byte(kind_t k, logic [7:0] ch, logic [3:0] idx);
		logic [7:0] b;
		b = CH_SP;
		case (k)
			K_ECHO:  b = ch;
			K_ERASE: b = (idx == 4'd1) ? CH_SP : CH_BS;
			K_CMD: begin
				case (idx)
					4'd0:    b = CH_CR;
					4'd1:    b = CH_LF;
					4'd2:    b = CH_GT;
					4'd3:    b = CH_SP;
					4'd4:    b = CH_BS;
					4'd5:    b = CH_BS;
					4'd6:    b = CH_SP;
					4'd7:    b = CH_BS;
					4'd8:    b = CH_GT;
					default: b = CH_SP;
				endcase
			end
			K_UNK: begin
				case (idx)
					4'd0:    b = CH_CR;
					4'd1:    b = CH_LF;
					4'd2:    b = CH_GT;
					4'd3:    b = CH_SP;
					4'd4:    b = CH_GT;
					default: b = CH_SP;
				endcase
			end
			default: b = ch;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

### sv/line_edit_on_off_command_parser.sv
// Line editor and ON/OFF command parser for a terminal byte stream.
//
// rx channel: one received byte per word (rx_valid / rx_stall / rx_byte).
// tx channel: one reply byte per word, with the event code, the on/off state
// after the causing byte and a last-of-run mark (tx_valid / tx_stall / ...).
//
// The front part classifies each byte, keeps the line length, the line-end
// flag and the on/off state, and queues a reply job. The back part plays a
// job out one byte per cycle, unless tx_stall holds it, into the output
// register. A taken byte's job is written into the queue, popped into the
// job register and then played out. Throughput: one tx word per cycle
// while tx_stall is low; a reply has 1 byte for echo, 3 for erase, 6 for
// unknown and 10 for on/off. Bytes with no reply queue no job.
// rx_stall rises only while the job queue is full, so input keeps flowing
// while the receiver stalls until QUEUE_DEPTH jobs are waiting.
// Reset: line empty, system off, queue and output register empty.
`default_nettype none
module line_edit_on_off_command_parser import lecp_pkg::*; #(
	parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
	parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rx_valid,
	output logic            rx_stall,
	input  wire logic [7:0] rx_byte,
	output logic            tx_valid,
	input  wire logic       tx_stall,
	output logic [7:0]      tx_byte,
	output logic [2:0]      event_res,
	output logic            system_is_on,
	output logic            last_of_run
);

	job_t push_job, head_job;
	logic push, pop, full, empty;

	// Front: classify, edit the line, decide the reply.
	lecp_front #(.LINE_CAPACITY(LINE_CAPACITY)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_byte  (rx_byte),
		.q_full   (full),
		.q_push   (push),
		.q_job    (push_job)
	);

	// Short queue decoupling the two sides.
	lecp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.full     (full),
		.empty    (empty)
	);

	// Back: sequence the reply bytes into the output register.
	lecp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_job        (head_job),
		.q_empty      (empty),
		.q_pop        (pop),
		.tx_valid     (tx_valid),
		.tx_stall     (tx_stall),
		.tx_byte      (tx_byte),
		.event_res    (event_res),
		.system_is_on (system_is_on),
		.last_of_run  (last_of_run)
	);

endmodule
`default_nettype wire

### sv/lecp_front.sv
`default_nettype none
module lecp_front import lecp_pkg::*; #(
	parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rx_valid,
	output logic            rx_stall,
	input  wire logic [7:0] rx_byte,
	input  wire logic       q_full,
	output logic            q_push,
	output job_t            q_job
);

	localparam int LEN_W = $clog2(LINE_CAPACITY);
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(LINE_CAPACITY - 1);

	logic [LEN_W-1:0] len_q;
	logic             ale_q;     // just after a line end
	logic             on_q;
	logic [6:0]       head_q [HEAD_N];

	logic accept, is_erase, is_eol, is_print, m_on, m_off;
	logic [1:0] hidx;

	assign rx_stall = q_full;
	assign accept   = rx_valid && !q_full;
	assign hidx     = len_q[1:0];

	assign is_erase = (rx_byte == CH_BS || rx_byte == CH_DEL) && (len_q != '0);
	assign is_eol   = (rx_byte == CH_CR || rx_byte == CH_LF);
	assign is_print = (rx_byte >= CH_SP) && (rx_byte <= CH_TIL) && (len_q < MAX_LEN);

	assign m_on  = (len_q == LEN_W'(2)) &&
		((head_q[0] == CH_UO && (head_q[1] == CH_UN || head_q[1] == CH_LN)) ||
		 (head_q[0] == CH_LO && head_q[1] == CH_LN));
	assign m_off = (len_q == LEN_W'(3)) &&
		((head_q[0] == CH_UO && head_q[1] == CH_UF && head_q[2] == CH_UF) ||
		 ((head_q[0] == CH_UO || head_q[0] == CH_LO) &&
		  head_q[1] == CH_LF7 && head_q[2] == CH_LF7));

	always_comb begin
		q_push     = 1'b0;
		q_job.kind = K_ECHO;
		q_job.ch   = rx_byte;
		q_job.ev   = EV_NONE;
		q_job.on   = on_q;
		if (accept) begin
			if (is_erase) begin
				q_push     = 1'b1;
				q_job.kind = K_ERASE;
			end else if (is_eol) begin
				q_push = !ale_q;
				if (m_on) begin
					q_job.kind = K_CMD;
					q_job.ev   = on_q ? EV_ALREADY_ON : EV_ON;
					q_job.on   = 1'b1;
				end else if (m_off) begin
					q_job.kind = K_CMD;
					q_job.ev   = on_q ? EV_OFF : EV_ALREADY_OFF;
					q_job.on   = 1'b0;
				end else begin
					q_job.kind = K_UNK;
					q_job.ev   = EV_UNKNOWN;
				end
			end else if (is_print) begin
				q_push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ale_q <= 1'b0;
			on_q  <= 1'b0;
		end else if (accept) begin
			if (is_erase) begin
				len_q <= len_q - LEN_W'(1);
				ale_q <= 1'b0;
			end else if (is_eol) begin
				if (ale_q) begin
					ale_q <= 1'b0;
				end else begin
					len_q <= '0;
					ale_q <= 1'b1;
					on_q  <= q_job.on;
				end
			end else if (is_print) begin
				len_q <= len_q + LEN_W'(1);
				ale_q <= 1'b0;
			end
		end
	end

	// Only the head of the line is kept; later characters are never matched.
	always_ff @(posedge clk) begin
		if (accept && !is_erase && !is_eol && is_print && len_q < LEN_W'(HEAD_N)) begin
			head_q[hidx] <= rx_byte[6:0];
		end
	end

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= MAX_LEN) else $error("line length beyond capacity");
	a_eol_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_eol && !ale_q |=> len_q == '0 && ale_q)
		else $error("line end did not reset the line");

endmodule
`default_nettype wire

### sv/lecp_queue.sv
`default_nettype none
module lecp_queue import lecp_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output job_t      head_job,
	output logic      full,
	output logic      empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign head_job = mem_q[rd_q];

	function automatic logic [PTR_W-1:0] nxt(logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= nxt(wr_q);
			if (pop)  rd_q <= nxt(rd_q);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_job;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("queue underflow");

endmodule
`default_nettype wire

### sv/lecp_back.sv
`default_nettype none
module lecp_back import lecp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire job_t q_job,
	input  wire logic q_empty,
	output logic      q_pop,
	output logic       tx_valid,
	input  wire logic  tx_stall,
	output logic [7:0] tx_byte,
	output logic [2:0] event_res,
	output logic       system_is_on,
	output logic       last_of_run
);

	job_t       job_q;
	logic       busy_q;
	logic [3:0] idx_q;
	logic       out_valid_q;
	logic [7:0] tx_q;
	event_t     ev_q;
	logic       on_q, last_q;

	logic advance, is_last;

	assign advance = !out_valid_q || !tx_stall;
	assign is_last = (idx_q == run_len(job_q.kind) - 4'd1);
	assign q_pop   = !q_empty && (!busy_q || (advance && is_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) out_valid_q <= busy_q;
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (advance && busy_q) begin
				if (is_last) busy_q <= 1'b0;
				else         idx_q  <= idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) job_q <= q_job;
		if (advance && busy_q) begin
			tx_q   <= run_byte(job_q.kind, job_q.ch, idx_q);
			ev_q   <= job_q.ev;
			on_q   <= job_q.on;
			last_q <= is_last;
		end
	end

	assign tx_valid     = out_valid_q;
	assign tx_byte      = tx_q;
	assign event_res    = ev_q;
	assign system_is_on = on_q;
	assign last_of_run  = last_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < run_len(job_q.kind)) else $error("run index out of range");
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_stall && !last_of_run |=> tx_valid)
		else $error("gap inside a reply run");
	a_on_state: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && (event_res == EV_ON || event_res == EV_ALREADY_ON) |-> system_is_on)
		else $error("on event with system off");
	a_off_state: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && (event_res == EV_OFF || event_res == EV_ALREADY_OFF) |-> !system_is_on)
		else $error("off event with system on");

endmodule
`default_nettype wire

### bench/line_edit_on_off_command_parser_tb.sv
`timescale 1ns / 1ps
module line_edit_on_off_command_parser_tb;
	import lecp_pkg::*;

	// The line holds one character fewer than its capacity.
	localparam int LINE_MAX     = LINE_CAPACITY_DEF - 1;
	// Long receiver hold-off: well beyond what the job queue can absorb.
	localparam int HOLD_CYCLES  = 80;
	// Quiet cycles after the last reply, to catch stray tx words.
	localparam int TAIL_CYCLES  = 20;
	localparam int RANDOM_ITEMS = 210;
	// Cap on printed mismatch lines; all of them are still counted.
	localparam int PRINT_CAP    = 50;

	// One rx word waiting to be offered, with markers that steer the driver.
	typedef struct {
		logic [7:0] b;
		bit         pause; // wait until every reply is in before offering
		bit         hold;  // ask the receiver for a long hold-off
		bit         quiet; // from here on neither side idles
	} rx_word_t;

	// One expected tx word.
	typedef struct packed {
		logic [7:0] tx;
		event_t     code;
		logic       on;
		logic       last;
	} reply_t;

	logic       clk     = 1'b0;
	logic       arst_n  = 1'b0;
	logic       rx_valid = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic       tx_stall = 1'b0;
	logic       rx_stall;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic [2:0] event_res;
	logic       system_is_on;
	logic       last_of_run;

	line_edit_on_off_command_parser i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_stall     (rx_stall),
		.rx_byte      (rx_byte),
		.tx_valid     (tx_valid),
		.tx_stall     (tx_stall),
		.tx_byte      (tx_byte),
		.event_res    (event_res),
		.system_is_on (system_is_on),
		.last_of_run  (last_of_run)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	rx_word_t rx_pending [$];
	reply_t   replies_due [$];

	// Shadow of the line editor state.
	logic [6:0] line_text [0:LINE_MAX-1];
	int         line_len    = 0;
	bit         after_end   = 1'b0;
	bit         sys_on      = 1'b0;

	int errors     = 0;
	int stim_count = 0;

	// Markers consumed by the next queued word.
	bit mark_pause = 1'b0;
	bit mark_hold  = 1'b0;
	bit mark_quiet = 1'b0;

	// Handshake bookkeeping shared between the clocked processes.
	bit started    = 1'b0; // first rising edge out of reset seen
	bit rx_taken   = 1'b0; // rx word accepted at the last rising edge
	bit hold_req   = 1'b0; // one-cycle request for the long hold-off
	bit quiet_tail = 1'b0;
	int rx_gap     = 0;
	int tx_gap     = 0;
	int hold_left  = 0;
	bit drv_hold;
	reply_t want;

	string cmd_words [0:12] = '{"ON", "On", "on", "OFF", "Off", "off",
		"oN", "OF", "of", "oFF", "ofF", "OFFx", "x"};

	task report_mismatch(input string what, input int got, input int wanted);
		errors++;
		if (errors <= PRINT_CAP)
			$display("%0t ns: %s: got %0h, want %0h", $time, what, got, wanted);
	endtask

	// Works out the tx words one rx byte causes and updates the shadow state.
	task automatic predict_reply(input logic [7:0] b);
		logic [7:0] seq [$];
		event_t     code;
		bit         word_on;
		bit         word_off;
		seq = {};
		code = EV_NONE;
		word_on = (line_len == 2) &&
			((line_text[0] == CH_UO && (line_text[1] == CH_UN || line_text[1] == CH_LN)) ||
			 (line_text[0] == CH_LO && line_text[1] == CH_LN));
		word_off = (line_len == 3) &&
			((line_text[0] == CH_UO && line_text[1] == CH_UF && line_text[2] == CH_UF) ||
			 ((line_text[0] == CH_UO || line_text[0] == CH_LO) &&
			  line_text[1] == CH_LF7 && line_text[2] == CH_LF7));
		if ((b == CH_BS || b == CH_DEL) && line_len > 0) begin
			line_len--;
			seq = '{CH_BS, CH_SP, CH_BS};
			after_end = 1'b0;
		end else if (b == CH_CR || b == CH_LF) begin
			if (after_end) begin
				// second half of a CR LF pair: swallowed
				after_end = 1'b0;
			end else begin
				seq = '{CH_CR, CH_LF, CH_GT, CH_SP};
				if (word_on) begin
					code = sys_on ? EV_ALREADY_ON : EV_ON;
					sys_on = 1'b1;
				end else if (word_off) begin
					code = sys_on ? EV_OFF : EV_ALREADY_OFF;
					sys_on = 1'b0;
				end else begin
					code = EV_UNKNOWN;
				end
				if (word_on || word_off) begin
					seq.push_back(CH_BS);
					seq.push_back(CH_BS);
					seq.push_back(CH_SP);
					seq.push_back(CH_BS);
				end
				seq.push_back(CH_GT);
				seq.push_back(CH_SP);
				line_len = 0;
				after_end = 1'b1;
			end
		end else if (b >= CH_SP && b <= CH_TIL && line_len < LINE_MAX) begin
			line_text[line_len] = b[6:0];
			line_len++;
			seq = '{b};
			after_end = 1'b0;
		end
		// erase on an empty line, a full line and other bytes: no reply
		foreach (seq[i])
			replies_due.push_back('{tx: seq[i], code: code, on: sys_on,
				last: (i == seq.size() - 1)});
	endtask

	task add_item(input logic [7:0] b, input bit counts);
		rx_word_t w;
		w.b = b;
		w.pause = mark_pause;
		w.hold = mark_hold;
		w.quiet = mark_quiet;
		mark_pause = 1'b0;
		mark_hold = 1'b0;
		mark_quiet = 1'b0;
		rx_pending.push_back(w);
		if (counts)
			stim_count++;
	endtask

	// Monitor: both handshakes are judged on the values settled since the
	// last falling edge.
	always @(posedge clk) begin
		started <= arst_n;
		rx_taken <= started && rx_valid && !rx_stall;
		if (started && rx_valid && !rx_stall) begin
			predict_reply(rx_byte);
			rx_pending.delete(0);
		end
		if (started && tx_valid && !tx_stall) begin
			if (replies_due.size() == 0) begin
				report_mismatch("tx word with no reply due", int'(tx_byte), 0);
			end else begin
				want = replies_due.pop_front();
				if (tx_byte !== want.tx)
					report_mismatch("tx_byte", int'(tx_byte), int'(want.tx));
				if (event_res !== want.code)
					report_mismatch("event_res", int'(event_res), int'(want.code));
				if (system_is_on !== want.on)
					report_mismatch("system_is_on", int'(system_is_on), int'(want.on));
				if (last_of_run !== want.last)
					report_mismatch("last_of_run", int'(last_of_run), int'(want.last));
			end
		end
	end

	// Driver: an offered word stays put until it is taken; valid never
	// looks at stall.
	always @(negedge clk) begin
		drv_hold = 1'b0;
		if (!started) begin
			rx_valid <= 1'b0;
		end else if (rx_valid && !rx_taken) begin
			// still waiting for the block to take it
		end else if (rx_gap != 0) begin
			rx_gap--;
			rx_valid <= 1'b0;
		end else if (rx_pending.size() == 0 ||
				(rx_pending[0].pause && replies_due.size() != 0)) begin
			rx_valid <= 1'b0;
		end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			// idle burst of random length
			rx_gap = $urandom_range(0, 5);
			rx_valid <= 1'b0;
		end else begin
			rx_valid <= 1'b1;
			rx_byte <= rx_pending[0].b;
			drv_hold = rx_pending[0].hold;
			if (rx_pending[0].quiet)
				quiet_tail <= 1'b1;
		end
		hold_req <= drv_hold;
	end

	// Receiver: random stall bursts, plus one long hold-off on request
	// so that the job queue fills and rx_stall has to rise.
	always @(negedge clk) begin
		if (!started) begin
			tx_stall <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			tx_stall <= 1'b1;
		end else if (hold_req) begin
			hold_left = HOLD_CYCLES - 1;
			tx_stall <= 1'b1;
		end else if (tx_gap != 0) begin
			tx_gap--;
			tx_stall <= 1'b1;
		end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			tx_gap = $urandom_range(0, 5);
			tx_stall <= 1'b1;
		end else begin
			tx_stall <= 1'b0;
		end
	end

	initial begin : stimulus
		int kind;
		int n;
		int k;
		string w;
		bit hold_marked;
		bit pause_marked;
		bit quiet_marked;
		hold_marked = 1'b0;
		pause_marked = 1'b0;
		quiet_marked = 1'b0;

		// Directed part, from reset: line empty, system off.
		add_item(CH_BS, 1);    // erase on an empty line: nothing
		add_item(CH_DEL, 1);   // same for DEL
		add_item(CH_CR, 1);    // empty line: unknown
		add_item(CH_LF, 1);    // swallowed after the line end
		add_item(CH_LF, 1);    // flag cleared, so unknown again
		add_item(CH_BS, 1);    // empty-line erase keeps the line-end flag
		add_item(CH_CR, 1);    // ... so this one is still swallowed
		add_item("o", 1);
		add_item("n", 1);
		add_item(CH_CR, 1);    // turned on
		add_item("O", 1);
		add_item("N", 1);
		add_item(CH_LF, 1);    // already on
		add_item("O", 1);
		add_item("f", 1);
		add_item("f", 1);
		add_item(CH_CR, 1);    // turned off
		add_item("O", 1);
		add_item("F", 1);
		add_item("F", 1);
		add_item(CH_LF, 1);    // already off
		add_item(8'h00, 1);    // control byte: ignored
		add_item(8'hFF, 1);    // high byte: ignored
		add_item(CH_SP, 1);
		add_item(CH_TIL, 1);
		add_item(CH_DEL, 1);   // erases the tilde
		add_item(CH_CR, 1);    // " " left: unknown

		// Random part. It opens, after a full drain, with a line pushed
		// past capacity: the surplus is dropped, an erase makes room again.
		mark_pause = 1'b1;
		for (k = 0; k < LINE_MAX + 3; k++)
			add_item(8'($urandom_range(CH_SP, CH_TIL)), 1);
		add_item(CH_DEL, 1);
		add_item("x", 1);
		add_item(CH_CR, 1);

		while (stim_count < RANDOM_ITEMS) begin
			if (!hold_marked && stim_count >= 80) begin
				mark_hold = 1'b1;
				hold_marked = 1'b1;
			end
			if (!pause_marked && stim_count >= 140) begin
				mark_pause = 1'b1;
				pause_marked = 1'b1;
			end
			if (!quiet_marked && stim_count >= RANDOM_ITEMS - 30) begin
				mark_quiet = 1'b1;
				quiet_marked = 1'b1;
			end
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				// command word, now and then after typed-and-erased junk
				if ($urandom_range(0, 2) == 0) begin
					n = $urandom_range(1, 3);
					for (k = 0; k < n; k++)
						add_item(8'($urandom_range(CH_SP, CH_TIL)), 1);
					for (k = 0; k < n; k++)
						add_item($urandom_range(0, 1) ? CH_BS : CH_DEL, 1);
				end
				w = cmd_words[$urandom_range(0, 12)];
				for (k = 0; k < w.len(); k++)
					add_item(w[k], 1);
			end else if (kind <= 7) begin
				// free text, erasures sometimes running past the start
				n = $urandom_range(0, 8);
				for (k = 0; k < n; k++)
					add_item(8'($urandom_range(CH_SP, CH_TIL)), 1);
				n = $urandom_range(0, n + 2);
				for (k = 0; k < n; k++)
					add_item($urandom_range(0, 1) ? CH_BS : CH_DEL, 1);
			end else begin
				// raw noise over the whole byte range
				n = $urandom_range(1, 4);
				for (k = 0; k < n; k++)
					add_item(8'($urandom_range(0, 255)), 0);
			end
			add_item($urandom_range(0, 1) ? CH_CR : CH_LF, 1);
			if ($urandom_range(0, 2) == 0)
				add_item($urandom_range(0, 1) ? CH_CR : CH_LF, 1);
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (rx_pending.size() != 0 || replies_due.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("line_edit_on_off_command_parser_tb: clean");
		else
			$display("line_edit_on_off_command_parser_tb: errors");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("line_edit_on_off_command_parser_tb: errors");
		$finish;
	end

endmodule

### files.f
sv/lecp_pkg.sv
sv/lecp_front.sv
sv/lecp_queue.sv
sv/lecp_back.sv
sv/line_edit_on_off_command_parser.sv
bench/line_edit_on_off_command_parser_tb.sv
